[design/rhmm_pkg.sv]
// ----------------------------------------------------------------------------
// rhmm_pkg
// shared types, constants and the bin index function of the rgb histogram unit
// ----------------------------------------------------------------------------
package rhmm_pkg;

  localparam int BIN_ENTRIES = 64;
  localparam int COUNT_BITS  = 32;
  localparam int BIN_W       = (BIN_ENTRIES > 1) ? $clog2(BIN_ENTRIES) : 1;
  localparam int CHANNELS    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAN_TOP = 8'd255;
  localparam logic [5:0] BIN_COUNT_RESET = 6'd63;

  // channel slots
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // func codes of an input item
  localparam logic [1:0] FN_ACC    = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] red_value;
    logic [7:0] green_value;
    logic [7:0] blue_value;
    logic [5:0] bin_index;
  } in_t;

  typedef struct packed {
    logic [31:0] red_count;
    logic [31:0] green_count;
    logic [31:0] blue_count;
    logic [7:0]  red_min;
    logic [7:0]  red_max;
    logic [7:0]  green_min;
    logic [7:0]  green_max;
    logic [7:0]  blue_min;
    logic [7:0]  blue_max;
  } out_t;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_CLEAR
  } op_kind_t;

  // classified item passed from front to back
  typedef struct packed {
    op_kind_t                        kind;
    logic [CHANNELS-1:0][7:0]        value;
    logic [CHANNELS-1:0][BIN_W-1:0]  bin;
    logic                            out_of_range;
  } op_t;

  // bin_count * v / 255, divide done by reciprocal (exact below 65535)
  function automatic logic [BIN_W-1:0] bin_of(input logic [5:0] bin_count,
                                              input logic [7:0] v);
    logic [13:0] prod;
    logic [14:0] sum;
    logic [6:0]  quo;
    prod = 14'(bin_count) * 14'(v);
    sum  = 15'(prod) + 15'(prod >> 8) + 15'd1;
    quo  = sum[14:8];
    if (32'(quo) > BIN_ENTRIES - 1) begin
      return BIN_W'(BIN_ENTRIES - 1);
    end
    return BIN_W'(quo);
  endfunction

  // clamp a stored count to the 32-bit result field
  function automatic logic [31:0] count_out(input logic [COUNT_BITS-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    if (wide > 64'hFFFF_FFFF) begin
      return 32'hFFFF_FFFF;
    end
    return wide[31:0];
  endfunction

endpackage

[design/rgb_histogram_min_max_top.sv]
// ----------------------------------------------------------------------------
// rgb_histogram_min_max_top
// per-channel histogram and min/max statistics over a stream of rgb pixels
// ----------------------------------------------------------------------------
//
// channel   ports                               carries
// -------   ---------------------------------   --------------------------------
// input     in_valid / in_ready / in_data       accumulate, read or clear item
// result    out_valid / out_ready / out_data    counts at one bin plus extremes
// config    cfg_wr_en / cfg_wr_data             bin_count scale, no wait state
//
// the front takes one item per cycle while the two-entry queue has room;
// the back reads the bin memory for an accumulate or read in S_IDLE, then in
// S_EXEC uses the registered read data to write or load the result; a clear
// completes in S_IDLE; the back pops no new item until it is done with the
// last, so the bin memory read-modify-write in the back sets the sustained rate
// synchronous active-low reset: bin_count 63, all bins read as zero through
// per-entry valid bits, minima 255, maxima 0; a clear item resets all but bin_count
// a result held at the output stalls only the back; the front keeps filling
// the queue until it is full
// ----------------------------------------------------------------------------
module rgb_histogram_min_max_top import rhmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  // bin scale register
  logic [5:0] bin_count_r;

  // front to queue
  logic q_push;
  op_t  q_push_op;
  logic q_full;

  // queue to back
  logic q_valid;
  op_t  q_head;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= BIN_COUNT_RESET;
    end else if (cfg_wr_en) begin
      bin_count_r <= cfg_wr_data;
    end
  end

  // decode item, compute bin addresses
  rhmm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .bin_count (bin_count_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_op      (q_push_op)
  );

  // decouples front from back stalls
  rhmm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // bin memories, extremes and result register
  rhmm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[design/rhmm_front.sv]
// ----------------------------------------------------------------------------
// rhmm_front
// accepts items, decodes func and works out the bin address of each channel
// ----------------------------------------------------------------------------
module rhmm_front import rhmm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  input  logic [5:0] bin_count,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  logic accept;
  logic unused_code;
  logic [7:0] seen_r;
  logic [7:0] seen_nxt;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  // unused code is taken and dropped
  assign unused_code = (in_data.func != FN_ACC) && (in_data.func != FN_READ) &&
                       (in_data.func != FN_CLEAR);
  assign q_push      = accept && !unused_code;

  // free-running item counter, wraps; kept for debug visibility
  assign seen_nxt = seen_r + 8'(q_push);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  always_comb begin
    q_op = '0;
    q_op.value[CH_RED]   = in_data.red_value;
    q_op.value[CH_GREEN] = in_data.green_value;
    q_op.value[CH_BLUE]  = in_data.blue_value;
    unique case (in_data.func)
      FN_ACC: begin
        q_op.kind          = OP_ACC;
        q_op.bin[CH_RED]   = bin_of(bin_count, in_data.red_value);
        q_op.bin[CH_GREEN] = bin_of(bin_count, in_data.green_value);
        q_op.bin[CH_BLUE]  = bin_of(bin_count, in_data.blue_value);
      end
      FN_READ: begin
        q_op.kind          = OP_READ;
        q_op.bin[CH_RED]   = BIN_W'(in_data.bin_index);
        q_op.bin[CH_GREEN] = BIN_W'(in_data.bin_index);
        q_op.bin[CH_BLUE]  = BIN_W'(in_data.bin_index);
        q_op.out_of_range  = (32'(in_data.bin_index) >= BIN_ENTRIES) || (seen_r == 8'hFF &&
                             32'(in_data.bin_index) >= BIN_ENTRIES);
      end
      default: begin
        q_op.kind = OP_CLEAR;
      end
    endcase
  end

endmodule

[design/rhmm_queue.sv]
// ----------------------------------------------------------------------------
// rhmm_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module rhmm_queue import rhmm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  head
);

  op_t                 slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     fill_r;
  logic [QPTR_W:0]     fill_nxt;

  assign full  = (32'(fill_r) == QUEUE_DEPTH);
  assign valid = (fill_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !(pop && valid)) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && pop && valid) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[design/rhmm_back.sv]
// ----------------------------------------------------------------------------
// rhmm_back
// executes items: bin read-modify-write, min/max tracking, reads and clears
// ----------------------------------------------------------------------------
module rhmm_back import rhmm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  op_t  q_head,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   out_valid_r;
  out_t   out_data_r;

  logic [COUNT_BITS-1:0]  mem [CHANNELS][BIN_ENTRIES];
  logic [BIN_ENTRIES-1:0] vld_r [CHANNELS];
  logic [COUNT_BITS-1:0]  rd_q_r [CHANNELS];
  logic [CHANNELS-1:0]    rd_vld_r;
  logic [7:0]             lo_r [CHANNELS];
  logic [7:0]             hi_r [CHANNELS];

  logic                   rd_en;
  logic                   wr_en;
  logic [COUNT_BITS-1:0]  cur [CHANNELS];
  logic [COUNT_BITS-1:0]  wr_data [CHANNELS];
  logic                   out_free;
  logic                   out_load;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign rd_en     = q_pop && (q_head.kind != OP_CLEAR);
  assign wr_en     = (state_r == S_EXEC) && (op_r.kind == OP_ACC);
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == S_EXEC) && (op_r.kind != OP_ACC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // unwritten entries read as zero; saturating increment
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      cur[c]     = rd_vld_r[c] ? rd_q_r[c] : '0;
      wr_data[c] = (cur[c] == '1) ? cur[c] : cur[c] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (rd_en) begin
        rd_q_r[c] <= mem[c][q_head.bin[c]];
      end
      if (wr_en) begin
        mem[c][op_r.bin[c]] <= wr_data[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        vld_r[c] <= '0;
        lo_r[c]  <= CHAN_TOP;
        hi_r[c]  <= '0;
      end
    end else begin
      // a new result replaces the one taken in the same cycle
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            op_r <= q_head;
            if (q_head.kind == OP_CLEAR) begin
              for (int c = 0; c < CHANNELS; c++) begin
                vld_r[c] <= '0;
                lo_r[c]  <= CHAN_TOP;
                hi_r[c]  <= '0;
              end
            end else begin
              for (int c = 0; c < CHANNELS; c++) begin
                rd_vld_r[c] <= vld_r[c][q_head.bin[c]];
              end
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (op_r.kind == OP_ACC) begin
            for (int c = 0; c < CHANNELS; c++) begin
              vld_r[c][op_r.bin[c]] <= 1'b1;
              if (op_r.value[c] < lo_r[c]) begin
                lo_r[c] <= op_r.value[c];
              end
              if (op_r.value[c] > hi_r[c]) begin
                hi_r[c] <= op_r.value[c];
              end
            end
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_data_r.red_count   <= op_r.out_of_range ? '0 : count_out(cur[CH_RED]);
            out_data_r.green_count <= op_r.out_of_range ? '0 : count_out(cur[CH_GREEN]);
            out_data_r.blue_count  <= op_r.out_of_range ? '0 : count_out(cur[CH_BLUE]);
            out_data_r.red_min     <= lo_r[CH_RED];
            out_data_r.red_max     <= hi_r[CH_RED];
            out_data_r.green_min   <= lo_r[CH_GREEN];
            out_data_r.green_max   <= hi_r[CH_GREEN];
            out_data_r.blue_min    <= lo_r[CH_BLUE];
            out_data_r.blue_max    <= hi_r[CH_BLUE];
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[bench/tb_rgb_histogram_min_max_top.sv]
// ----------------------------------------------------------------------------
// tb_rgb_histogram_min_max_top
// self-checking bench for the rgb histogram and min/max statistics unit:
// items go in through a queue-fed driver, a predictor tracks bins and extremes
// at every accepted item, and each read result is compared field by field
// ----------------------------------------------------------------------------
module tb_rgb_histogram_min_max_top import rhmm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // func code the block must ignore
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam int MAX_WAIT      = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 160;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  in_t        in_data     = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  out_t       out_data;
  logic       cfg_wr_en   = 1'b0;
  logic [5:0] cfg_wr_data = '0;

  rgb_histogram_min_max_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // predicted state of the block
  // --------------------------------------------------------------------------
  bit [COUNT_BITS-1:0] hist [CHANNELS][BIN_ENTRIES];
  bit [7:0]            seen_min [CHANNELS];
  bit [7:0]            seen_max [CHANNELS];
  bit [5:0]            scale;

  out_t reads_due[$];      // bin reads still owed by the block, oldest first
  in_t  items_waiting[$];  // items not yet handed to the driver

  int items_queued = 0;
  int items_taken  = 0;
  int mismatches   = 0;

  // handshakes seen at the last rising edge, used by the driver at the falling edge
  bit in_fire  = 1'b0;
  bit out_fire = 1'b0;

  int gap_left   = 0;
  int stall_left = 0;
  bit send_calm  = 1'b0;
  bit recv_calm  = 1'b0;

  // zero every bin, minima back to the top value, maxima to zero
  function automatic void clear_statistics();
    foreach (hist[c, b]) hist[c][b] = '0;
    foreach (seen_min[c]) begin
      seen_min[c] = CHAN_TOP;
      seen_max[c] = '0;
    end
  endfunction

  // a stored count clamped to the 32-bit result field
  function automatic bit [31:0] count_field(bit [COUNT_BITS-1:0] n);
    return (64'(n) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n);
  endfunction

  // advance the statistics by one accepted item, queue the result of a read
  function automatic void update_statistics(in_t item);
    bit [7:0] v [CHANNELS];
    int       b;
    out_t     r;
    v[CH_RED]   = item.red_value;
    v[CH_GREEN] = item.green_value;
    v[CH_BLUE]  = item.blue_value;
    case (item.func)
      FN_ACC: begin
        for (int c = 0; c < CHANNELS; c++) begin
          // bin scale*value/255, truncated; value 255 lands in bin scale
          b = (int'(scale) * int'(v[c])) / int'(CHAN_TOP);
          if (b > BIN_ENTRIES - 1) b = BIN_ENTRIES - 1;
          // counts stick at all ones instead of wrapping
          if (hist[c][b] != '1) hist[c][b] = hist[c][b] + 1'b1;
          if (v[c] < seen_min[c]) seen_min[c] = v[c];
          if (v[c] > seen_max[c]) seen_max[c] = v[c];
        end
      end
      FN_CLEAR: clear_statistics();
      FN_READ: begin
        r = '0;
        // a bin past the table reads as zero counts, extremes still returned
        if (int'(item.bin_index) < BIN_ENTRIES) begin
          r.red_count   = count_field(hist[CH_RED][item.bin_index]);
          r.green_count = count_field(hist[CH_GREEN][item.bin_index]);
          r.blue_count  = count_field(hist[CH_BLUE][item.bin_index]);
        end
        r.red_min   = seen_min[CH_RED];
        r.red_max   = seen_max[CH_RED];
        r.green_min = seen_min[CH_GREEN];
        r.green_max = seen_max[CH_GREEN];
        r.blue_min  = seen_min[CH_BLUE];
        r.blue_max  = seen_max[CH_BLUE];
        reads_due.push_back(r);
      end
      default: ; // unused code changes nothing
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
    end
  endfunction

  function automatic void check_read(out_t got);
    out_t want;
    if (reads_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: result with nothing outstanding: %p", $realtime, got);
      return;
    end
    want = reads_due.pop_front();
    check_field("red_count",   want.red_count,        got.red_count);
    check_field("green_count", want.green_count,      got.green_count);
    check_field("blue_count",  want.blue_count,       got.blue_count);
    check_field("red_min",     32'(want.red_min),     32'(got.red_min));
    check_field("red_max",     32'(want.red_max),     32'(got.red_max));
    check_field("green_min",   32'(want.green_min),   32'(got.green_min));
    check_field("green_max",   32'(want.green_max),   32'(got.green_max));
    check_field("blue_min",    32'(want.blue_min),    32'(got.blue_min));
    check_field("blue_max",    32'(want.blue_max),    32'(got.blue_max));
  endfunction

  // --------------------------------------------------------------------------
  // monitor: both channels and the config port at the rising edge
  // results are checked before the same edge's input is predicted, so an
  // early result can never match a read accepted at the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_fire = (rst_n && out_valid && out_ready) === 1'b1;
    in_fire  = (rst_n && in_valid && in_ready) === 1'b1;
    if (!rst_n) begin
      scale = BIN_COUNT_RESET;
      clear_statistics();
    end else begin
      if (out_fire) check_read(out_data);
      if (in_fire) begin
        update_statistics(in_data);
        items_taken++;
      end
      if (cfg_wr_en) scale = cfg_wr_data;
    end
  end

  // per-item wait, with occasional stretches where a side never idles
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  // --------------------------------------------------------------------------
  // driver: input items and result back-pressure change at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) gap_left = draw_wait(send_calm);
      // valid holds with the same item until it is taken
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (items_waiting.size() > 0) begin
          in_data  <= items_waiting.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_fire) stall_left = draw_wait(recv_calm);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(logic [1:0] func, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [5:0] idx);
    in_t item;
    item.func        = func;
    item.red_value   = r;
    item.green_value = g;
    item.blue_value  = b;
    item.bin_index   = idx;
    items_waiting.push_back(item);
    items_queued++;
  endtask

  // pixel channel: extremes now and then, otherwise anywhere in range
  function automatic logic [7:0] pixel_value();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CHAN_TOP : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // read mostly the bins in use at the present scale, sometimes any bin
  function automatic logic [5:0] read_bin();
    if ($urandom_range(0, 3) != 0) return 6'($urandom_range(0, int'(scale)));
    return 6'($urandom_range(0, 63));
  endfunction

  // mostly pixels and reads, a few clears; unused codes come on top
  task automatic random_phase(int n);
    int counted;
    int pick;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_item(FN_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom));
      end else begin
        counted++;
        if (pick < 60)
          queue_item(FN_ACC, pixel_value(), pixel_value(), pixel_value(), 6'($urandom));
        else if (pick < 96)
          queue_item(FN_READ, 8'($urandom), 8'($urandom), 8'($urandom), read_bin());
        else
          queue_item(FN_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom));
      end
    end
  endtask

  // block idle: every item taken, every read answered, back end given time
  task automatic drain();
    while (items_taken != items_queued || reads_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(logic [5:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // run control
  // --------------------------------------------------------------------------
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int scale_plan[$];
    scale_plan = '{1, 0, 63, 32, 7, 2, 62};
    scale_plan.push_back(int'($urandom_range(0, 63)));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset scale
    // empty statistics: minima at the top value, maxima at zero
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd0);
    queue_item(FN_READ, 8'hFF, 8'hFF, 8'hFF, 6'd63);
    // unused code with every field bit set must leave no trace
    queue_item(FN_UNUSED, 8'hFF, 8'hFF, 8'hFF, 6'd63);
    queue_item(FN_ACC, 8'd0, 8'd0, 8'd0, 6'd0);
    queue_item(FN_ACC, 8'd255, 8'd255, 8'd255, 6'd63);
    queue_item(FN_ACC, 8'd0, 8'd255, 8'd128, 6'd0);
    queue_item(FN_ACC, 8'd255, 8'd0, 8'd1, 6'd0);
    queue_item(FN_ACC, 8'd128, 8'd1, 8'd254, 6'd0);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd0);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd63);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd32);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd62);
    queue_item(FN_CLEAR, 8'hFF, 8'hFF, 8'hFF, 6'd63);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd0);
    // mid-range pixels with opposite bit patterns
    queue_item(FN_ACC, 8'hAA, 8'h55, 8'h0F, 6'd0);
    queue_item(FN_ACC, 8'h55, 8'hAA, 8'hF0, 6'd0);
    queue_item(FN_ACC, 8'd200, 8'd100, 8'd50, 6'd0);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd21);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd42);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd49);
    queue_item(FN_UNUSED, 8'd0, 8'd0, 8'd0, 6'd0);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd63);
    queue_item(FN_CLEAR, 8'd0, 8'd0, 8'd0, 6'd0);
    queue_item(FN_READ, 8'd0, 8'd0, 8'd0, 6'd63);
    random_phase(PHASE_ITEMS);

    // one phase per scale, including zero where every value goes to bin 0
    foreach (scale_plan[i]) begin
      drain();
      write_scale(6'(scale_plan[i]));
      random_phase(PHASE_ITEMS);
    end

    drain();
    if (mismatches == 0 && reads_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
